[design/wsfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types, constants and helpers of the websocket frame encoder.
// ----------------------------------------------------------------------------
package wsfe_pkg;

    localparam logic       MODE_START   = 1'b0;
    localparam logic       MODE_PAYLOAD = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_OVERRUN   = 2'd2;

    localparam logic [15:0] SHORT_MAX   = 16'h007D;
    localparam logic [6:0]  EXT16_CODE  = 7'h7E;
    localparam logic [15:0] LEN_LIMIT   = 16'hFFFF;

    localparam logic [2:0] HDR_SHORT    = 3'd2;
    localparam logic [2:0] HDR_EXT16    = 3'd4;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_last;
        logic [1:0] status;
    } t_res;

    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

[design/websocket_frame_encoder.sv]
`timescale 1ns / 1ps
// Websocket frame encoder: a start item (mode 0) emits the frame header one byte
// per cycle while the output queue has space, 2 to 8 bytes (type, length code,
// optional 16-bit length, optional four key bytes), or a single status byte for
// an oversize length, holding the input until its last byte is pushed; a
// payload item (mode 1) emits one masked byte, so payload streams at one byte
// per clock while the output queue has space. The rate is set by the single
// output byte lane. The first output byte passes the input register and then
// the output queue before it is offered. Status 1 flags a length of 65535 or
// more, status 2 a payload byte beyond the announced length.
// ----------------------------------------------------------------------------
// websocket_frame_encoder
// Frame header generation and payload masking with valid/ready channels.
// ----------------------------------------------------------------------------
module websocket_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_frame_type,
    input  logic        i_mask_enable,
    input  logic [31:0] i_mask_key,
    input  logic [15:0] i_frame_length,
    input  logic [7:0]  i_payload_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_last,
    output logic [1:0]  o_status
);
    import wsfe_pkg::*;

    logic push;
    logic space;
    t_res enc_res;
    t_res out_res;

    wsfe_enc u_enc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_frame_type   (i_frame_type),
        .i_mask_enable  (i_mask_enable),
        .i_mask_key     (i_mask_key),
        .i_frame_length (i_frame_length),
        .i_payload_byte (i_payload_byte),
        .i_space        (space),
        .o_push         (push),
        .o_res          (enc_res)
    );

    wsfe_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (enc_res),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_out_byte   = out_res.out_byte;
    assign o_frame_last = out_res.frame_last;
    assign o_status     = out_res.status;

endmodule

[design/wsfe_enc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfe_enc
// Input register, header byte sequencer, payload masking and frame state.
// ----------------------------------------------------------------------------
module wsfe_enc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [7:0]        i_frame_type,
    input  logic              i_mask_enable,
    input  logic [31:0]       i_mask_key,
    input  logic [15:0]       i_frame_length,
    input  logic [7:0]        i_payload_byte,
    input  logic              i_space,
    output logic              o_push,
    output wsfe_pkg::t_res    o_res
);
    import wsfe_pkg::*;

    logic        r_in_vld;
    logic        r_mode;
    logic [7:0]  r_type;
    logic        r_men;
    logic [31:0] r_key;
    logic [15:0] r_len;
    logic [7:0]  r_pay;
    logic [2:0]  r_idx;

    logic [31:0] r_key_store;
    logic        r_masking_on;
    logic [1:0]  r_key_pos;
    logic [15:0] r_rem;

    logic        too_long;
    logic        short_len;
    logic        empty;
    logic [2:0]  hdr_len;
    logic [3:0]  n_bytes;
    logic        last_step;
    logic [2:0]  key_off;
    logic [7:0]  hdr_key;
    logic [7:0]  hdr_byte;
    logic        fire;
    logic        consume;
    logic        accept;
    t_res        res;

    always_comb begin
        too_long  = (r_len == LEN_LIMIT);
        short_len = (r_len <= SHORT_MAX);
        empty     = (r_len == 16'd0);
        hdr_len   = short_len ? HDR_SHORT : HDR_EXT16;
        n_bytes   = too_long ? 4'd1 : ({1'b0, hdr_len} + (r_men ? KEY_BYTES : 4'd0));
        last_step = ({1'b0, r_idx} == (n_bytes - 4'd1));
        key_off   = r_idx - hdr_len;
        hdr_key   = key_byte(r_key, key_off[1:0]);
        case (r_idx)
            3'd0:    hdr_byte = r_type;
            3'd1:    hdr_byte = short_len ? {r_men, r_len[6:0]} : {r_men, EXT16_CODE};
            3'd2:    hdr_byte = short_len ? hdr_key : r_len[15:8];
            3'd3:    hdr_byte = short_len ? hdr_key : r_len[7:0];
            default: hdr_byte = hdr_key;
        endcase

        if (r_mode == MODE_START) begin
            if (too_long) begin
                res.out_byte   = 8'd0;
                res.frame_last = 1'b1;
                res.status     = ST_TOO_LONG;
            end else begin
                res.out_byte   = hdr_byte;
                res.frame_last = empty && last_step;
                res.status     = ST_OK;
            end
        end else if (r_rem == 16'd0) begin
            res.out_byte   = 8'd0;
            res.frame_last = 1'b0;
            res.status     = ST_OVERRUN;
        end else begin
            res.out_byte   = r_pay ^ (r_masking_on ? key_byte(r_key_store, r_key_pos) : 8'd0);
            res.frame_last = (r_rem == 16'd1);
            res.status     = ST_OK;
        end

        fire    = r_in_vld && i_space;
        consume = fire && ((r_mode == MODE_PAYLOAD) || last_step);
        accept  = i_valid && o_ready;
    end

    assign o_ready = !r_in_vld || consume;
    assign o_push  = fire;
    assign o_res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_idx        <= 3'd0;
            r_key_store  <= 32'd0;
            r_masking_on <= 1'b0;
            r_key_pos    <= 2'd0;
            r_rem        <= 16'd0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (consume) begin
                r_in_vld <= 1'b0;
            end

            if (fire && (r_mode == MODE_START)) begin
                r_idx <= last_step ? 3'd0 : r_idx + 3'd1;
                if (r_idx == 3'd0) begin
                    r_key_pos <= 2'd0;
                    if (too_long) begin
                        r_rem        <= 16'd0;
                        r_masking_on <= 1'b0;
                    end else begin
                        r_rem        <= r_len;
                        r_masking_on <= r_men;
                        r_key_store  <= r_key;
                    end
                end
            end

            if (fire && (r_mode == MODE_PAYLOAD) && (r_rem != 16'd0)) begin
                r_key_pos <= r_key_pos + 2'd1;
                r_rem     <= r_rem - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_type <= i_frame_type;
            r_men  <= i_mask_enable;
            r_key  <= i_mask_key;
            r_len  <= i_frame_length;
            r_pay  <= i_payload_byte;
        end
    end

endmodule

[design/wsfe_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfe_obuf
// Two-entry output queue that decouples the encoder from downstream stalls.
// ----------------------------------------------------------------------------
module wsfe_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsfe_pkg::t_res    i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output wsfe_pkg::t_res    o_res
);
    import wsfe_pkg::*;

    t_res       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

endmodule
